FILE: sv/eight_channel_dma_controller_macros.svh
// assertion macros shared by the dma controller rtl
// no dependencies; each file that asserts includes this header
`ifndef EIGHT_CHANNEL_DMA_CONTROLLER_MACROS_SVH
`define EIGHT_CHANNEL_DMA_CONTROLLER_MACROS_SVH

// same-cycle implication, checked on every edge out of reset
`define ECDMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecdma check failed: same-cycle implication");

// next-cycle implication
`define ECDMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecdma check failed: next-cycle implication");

`endif

FILE: sv/ecdma_pkg.sv
// types, constants and tables for the eight channel dma controller
// no dependencies; used by ecdma_move_unit and the top level
`timescale 1ns / 1ps

package ecdma_pkg;

  // number of implemented channels (1 to 8); the address field always has 3 channel bits
  localparam int CHANNEL_COUNT = 8;
  localparam int MAX_CHANNELS  = 8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // register index within a channel
  localparam logic [3:0] REG_CONTROL    = 4'h0;
  localparam logic [3:0] REG_B_BASE     = 4'h1;
  localparam logic [3:0] REG_A_OFF_LO   = 4'h2;
  localparam logic [3:0] REG_A_OFF_HI   = 4'h3;
  localparam logic [3:0] REG_A_BANK     = 4'h4;
  localparam logic [3:0] REG_COUNT_LO   = 4'h5;
  localparam logic [3:0] REG_COUNT_HI   = 4'h6;
  localparam logic [3:0] REG_IND_BANK   = 4'h7;
  localparam logic [3:0] REG_TABLE_LO   = 4'h8;
  localparam logic [3:0] REG_TABLE_HI   = 4'h9;
  localparam logic [3:0] REG_LINE_COUNT = 4'ha;
  localparam logic [3:0] REG_SPARE      = 4'hb;
  localparam logic [3:0] REG_SPARE_ALT  = 4'hf;

  // bit positions inside the 5-bit flag field
  localparam int FLAG_FIXED     = 0;
  localparam int FLAG_DECREMENT = 1;
  localparam int FLAG_FROM_B    = 4;

  // wait timer increments and decrement
  localparam logic [7:0] TIMER_START  = 8'd16;
  localparam logic [7:0] TIMER_MOVE   = 8'd6;
  localparam logic [7:0] TIMER_FINISH = 8'd8;
  localparam logic [7:0] TIMER_TICK   = 8'd2;

  typedef struct packed {
    logic        from_b;
    logic [23:0] a_address;
    logic [7:0]  b_address;
    logic        last;
  } move_t;

  typedef struct packed {
    logic [15:0] a_offset;
    logic [15:0] byte_count;
    logic [1:0]  step;
    logic        done;
  } chan_upd_t;

  // b-bus offset by transfer mode and step within the pattern
  function automatic logic [1:0] b_offset(input logic [2:0] mode, input logic [1:0] step);
    logic [1:0] r;
    r = 2'd0;
    unique case (mode)
      3'd1, 3'd5: r = {1'b0, step[0]};
      3'd3, 3'd7: r = {1'b0, step[1]};
      3'd4:       r = step;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ecdma_move_unit.sv
// one byte move for the selected channel: bus addresses and stepped channel state
// depends on ecdma_pkg
`timescale 1ns / 1ps

module ecdma_move_unit (
  input  logic [2:0]           mode,
  input  logic [4:0]           flags,
  input  logic [1:0]           step,
  input  logic [7:0]           b_base,
  input  logic [15:0]          a_offset,
  input  logic [7:0]           a_bank,
  input  logic [15:0]          byte_count,
  output ecdma_pkg::move_t     move,
  output ecdma_pkg::chan_upd_t upd
);

  logic [15:0] count_dec;

  assign count_dec = byte_count - 16'd1;

  always_comb begin
    move.from_b    = flags[ecdma_pkg::FLAG_FROM_B];
    move.a_address = {a_bank, a_offset};
    move.b_address = b_base + {6'd0, ecdma_pkg::b_offset(mode, step)};
    move.last      = (count_dec == 16'd0);
  end

  always_comb begin
    upd.byte_count = count_dec;
    upd.done       = (count_dec == 16'd0);
    upd.step       = upd.done ? 2'd0 : step + 2'd1;
    if (flags[ecdma_pkg::FLAG_FIXED]) begin
      upd.a_offset = a_offset;
    end else if (flags[ecdma_pkg::FLAG_DECREMENT]) begin
      upd.a_offset = a_offset - 16'd1;
    end else begin
      upd.a_offset = a_offset + 16'd1;
    end
  end

endmodule

FILE: sv/eight_channel_dma_controller.sv
// top level of the eight channel dma controller: channel register bank, engine state
// depends on ecdma_pkg, ecdma_move_unit and eight_channel_dma_controller_macros.svh
`timescale 1ns / 1ps
//
//  channel  handshake              word contents
//  -------  ---------------------  ----------------------------------------------
//  in       in_valid / in_ready    command, reg_address, write_data, start_mask
//  out      out_valid / out_ready  read_data, was_busy, move_*, one per in word
//
//  each word is registered first in the input register, then in the result
//  register; one word per cycle is sustained while out_ready holds, the update path
//  running from the input register through the engine state to the result
//  synchronous active-high rst puts every channel register at its reset value and
//  clears the engine, both stage valids and the timer
//  a stalled out side holds the result register; the input register then holds too
//  and in_ready drops only while both are full

module eight_channel_dma_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [6:0]  reg_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  start_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        was_busy,
  output logic        move_valid,
  output logic        move_from_b,
  output logic [23:0] move_a_address,
  output logic [7:0]  move_b_address,
  output logic        move_last
);

`include "eight_channel_dma_controller_macros.svh"

  localparam int NCH = ecdma_pkg::MAX_CHANNELS;

  // input register
  logic            s1_valid;
  ecdma_pkg::cmd_t s1_cmd;
  logic [6:0]      s1_addr;
  logic [7:0]      s1_data;
  logic [7:0]      s1_mask;
  logic            advance;

  // channel register bank
  logic [2:0]  chan_mode          [NCH];
  logic [4:0]  chan_flags         [NCH];
  logic [7:0]  chan_b_base        [NCH];
  logic [15:0] chan_a_offset      [NCH];
  logic [7:0]  chan_a_bank        [NCH];
  logic [15:0] chan_byte_count    [NCH];
  logic [7:0]  chan_indirect_bank [NCH];
  logic [15:0] chan_table_address [NCH];
  logic [7:0]  chan_line_count    [NCH];
  logic [7:0]  chan_spare_byte    [NCH];
  logic [1:0]  chan_offset_step   [NCH];
  logic [NCH-1:0] chan_active;

  // engine state
  logic [7:0]     wait_timer;
  logic [7:0]     wait_timer_next;
  logic           engine_busy;
  logic           engine_busy_next;
  logic [NCH-1:0] chan_active_next;

  // decode of the word in the input register
  logic [2:0] s1_ch;
  logic [3:0] s1_reg;
  logic       s1_ch_ok;
  logic [NCH-1:0] impl_mask;
  logic [NCH-1:0] start_sel;

  // lowest active channel
  logic       sel_found;
  logic [2:0] sel_ch;
  logic       do_move;
  logic       do_write;

  ecdma_pkg::move_t     mv;
  ecdma_pkg::chan_upd_t upd;

  // result computed from the input register
  logic [7:0] rd_byte;
  logic [7:0] res_read_data;
  logic       res_was_busy;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= ecdma_pkg::cmd_t'(command);
      s1_addr <= reg_address;
      s1_data <= write_data;
      s1_mask <= start_mask;
    end
  end

  assign s1_ch    = s1_addr[6:4];
  assign s1_reg   = s1_addr[3:0];
  assign s1_ch_ok = ({1'b0, s1_ch} < 4'(ecdma_pkg::CHANNEL_COUNT));

  // channels beyond the implemented count never start
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      impl_mask[i] = (i < ecdma_pkg::CHANNEL_COUNT);
    end
  end

  assign start_sel = s1_mask & impl_mask;

  // priority pick, channel 0 first
  always_comb begin
    sel_found = 1'b0;
    sel_ch    = 3'd0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (chan_active[i]) begin
        sel_found = 1'b1;
        sel_ch    = 3'(i);
      end
    end
  end

  ecdma_move_unit u_move (
    .mode       (chan_mode[sel_ch]),
    .flags      (chan_flags[sel_ch]),
    .step       (chan_offset_step[sel_ch]),
    .b_base     (chan_b_base[sel_ch]),
    .a_offset   (chan_a_offset[sel_ch]),
    .a_bank     (chan_a_bank[sel_ch]),
    .byte_count (chan_byte_count[sel_ch]),
    .move       (mv),
    .upd        (upd)
  );

  // a tick moves a byte only when busy with the timer run out
  assign do_move  = advance && (s1_cmd == ecdma_pkg::CMD_TICK) && engine_busy &&
                    (wait_timer == 8'd0) && sel_found;
  assign do_write = advance && (s1_cmd == ecdma_pkg::CMD_WRITE) && s1_ch_ok;

  // register read mux
  always_comb begin
    unique case (s1_reg)
      ecdma_pkg::REG_CONTROL:    rd_byte = {chan_flags[s1_ch], chan_mode[s1_ch]};
      ecdma_pkg::REG_B_BASE:     rd_byte = chan_b_base[s1_ch];
      ecdma_pkg::REG_A_OFF_LO:   rd_byte = chan_a_offset[s1_ch][7:0];
      ecdma_pkg::REG_A_OFF_HI:   rd_byte = chan_a_offset[s1_ch][15:8];
      ecdma_pkg::REG_A_BANK:     rd_byte = chan_a_bank[s1_ch];
      ecdma_pkg::REG_COUNT_LO:   rd_byte = chan_byte_count[s1_ch][7:0];
      ecdma_pkg::REG_COUNT_HI:   rd_byte = chan_byte_count[s1_ch][15:8];
      ecdma_pkg::REG_IND_BANK:   rd_byte = chan_indirect_bank[s1_ch];
      ecdma_pkg::REG_TABLE_LO:   rd_byte = chan_table_address[s1_ch][7:0];
      ecdma_pkg::REG_TABLE_HI:   rd_byte = chan_table_address[s1_ch][15:8];
      ecdma_pkg::REG_LINE_COUNT: rd_byte = chan_line_count[s1_ch];
      ecdma_pkg::REG_SPARE,
      ecdma_pkg::REG_SPARE_ALT:  rd_byte = chan_spare_byte[s1_ch];
      default:                   rd_byte = 8'd0; // unmapped registers read as zero
    endcase
  end

  assign res_read_data = ((s1_cmd == ecdma_pkg::CMD_READ) && s1_ch_ok) ? rd_byte : 8'd0;
  assign res_was_busy  = (s1_cmd == ecdma_pkg::CMD_TICK) && engine_busy;

  // engine next state: timer, busy, active set
  always_comb begin
    wait_timer_next  = wait_timer;
    engine_busy_next = engine_busy;
    chan_active_next = chan_active;
    if (advance) begin
      unique case (s1_cmd)
        ecdma_pkg::CMD_START: begin
          chan_active_next = start_sel;
          engine_busy_next = (start_sel != '0);
          if (start_sel != '0) begin
            wait_timer_next = wait_timer + ecdma_pkg::TIMER_START;
          end
        end
        ecdma_pkg::CMD_TICK: begin
          if (engine_busy) begin
            if (wait_timer != 8'd0) begin
              wait_timer_next = wait_timer - ecdma_pkg::TIMER_TICK;
            end else if (sel_found) begin
              // finishing channel adds its extra wait on top of the move
              wait_timer_next = wait_timer + ecdma_pkg::TIMER_MOVE +
                                (upd.done ? ecdma_pkg::TIMER_FINISH : 8'd0);
              if (upd.done) begin
                chan_active_next[sel_ch] = 1'b0;
              end
            end else begin
              engine_busy_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_timer  <= 8'd0;
      engine_busy <= 1'b0;
      chan_active <= '0;
    end else begin
      wait_timer  <= wait_timer_next;
      engine_busy <= engine_busy_next;
      chan_active <= chan_active_next;
    end
  end

  // channel register bank: cpu writes and the move write-back never coincide
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        chan_mode[i]          <= 3'd7;
        chan_flags[i]         <= 5'h1f;
        chan_b_base[i]        <= 8'hff;
        chan_a_offset[i]      <= 16'hffff;
        chan_a_bank[i]        <= 8'hff;
        chan_byte_count[i]    <= 16'hffff;
        chan_indirect_bank[i] <= 8'hff;
        chan_table_address[i] <= 16'hffff;
        chan_line_count[i]    <= 8'hff;
        chan_spare_byte[i]    <= 8'hff;
        chan_offset_step[i]   <= 2'd0;
      end
    end else if (do_write) begin
      unique case (s1_reg)
        ecdma_pkg::REG_CONTROL: begin
          chan_mode[s1_ch]  <= s1_data[2:0];
          chan_flags[s1_ch] <= s1_data[7:3];
        end
        ecdma_pkg::REG_B_BASE:     chan_b_base[s1_ch]                <= s1_data;
        ecdma_pkg::REG_A_OFF_LO:   chan_a_offset[s1_ch][7:0]         <= s1_data;
        ecdma_pkg::REG_A_OFF_HI:   chan_a_offset[s1_ch][15:8]        <= s1_data;
        ecdma_pkg::REG_A_BANK:     chan_a_bank[s1_ch]                <= s1_data;
        ecdma_pkg::REG_COUNT_LO:   chan_byte_count[s1_ch][7:0]       <= s1_data;
        ecdma_pkg::REG_COUNT_HI:   chan_byte_count[s1_ch][15:8]      <= s1_data;
        ecdma_pkg::REG_IND_BANK:   chan_indirect_bank[s1_ch]         <= s1_data;
        ecdma_pkg::REG_TABLE_LO:   chan_table_address[s1_ch][7:0]    <= s1_data;
        ecdma_pkg::REG_TABLE_HI:   chan_table_address[s1_ch][15:8]   <= s1_data;
        ecdma_pkg::REG_LINE_COUNT: chan_line_count[s1_ch]            <= s1_data;
        ecdma_pkg::REG_SPARE,
        ecdma_pkg::REG_SPARE_ALT:  chan_spare_byte[s1_ch]            <= s1_data;
        default: begin
        end
      endcase
    end else if (do_move) begin
      chan_a_offset[sel_ch]    <= upd.a_offset;
      chan_byte_count[sel_ch]  <= upd.byte_count;
      chan_offset_step[sel_ch] <= upd.step;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data      <= res_read_data;
      was_busy       <= res_was_busy;
      move_valid     <= do_move;
      move_from_b    <= do_move ? mv.from_b : 1'b0;
      move_a_address <= do_move ? mv.a_address : 24'd0;
      move_b_address <= do_move ? mv.b_address : 8'd0;
      move_last      <= do_move ? mv.last : 1'b0;
    end
  end

  // idle engine never holds an active channel
  `ECDMA_ASSERT_NOW(a_idle_no_active, !engine_busy, chan_active == '0)
  // a move only ever reports from a busy tick
  `ECDMA_ASSERT_NOW(a_move_busy, out_valid && move_valid, was_busy && read_data == 8'd0)
  // last flag only comes with a move
  `ECDMA_ASSERT_NOW(a_last_move, out_valid && move_last, move_valid)
  // start with any implemented channel leaves the engine busy
  `ECDMA_ASSERT_NEXT(a_start_busy,
      advance && s1_cmd == ecdma_pkg::CMD_START && start_sel != '0, engine_busy)

endmodule

FILE: test/tb_eight_channel_dma_controller.sv
// self-checking testbench for eight_channel_dma_controller: directed and random bus words
// depends on ecdma_pkg and the rtl top level; predicts each reply word with an in-bench engine model
`timescale 1ns / 1ps

module tb_eight_channel_dma_controller;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_WORDS     = 650;
  localparam int SETTLE_CYCLES    = 10;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 60;

  // register holes inside a channel
  localparam logic [3:0] REG_HOLE_LO  = 4'hc;
  localparam logic [3:0] REG_HOLE_MID = 4'hd;
  localparam logic [3:0] REG_HOLE_HI  = 4'he;

  // b-bus offset per mode, four 2-bit steps packed low step first
  localparam logic [7:0][7:0] B_PATTERN = {8'h50, 8'h00, 8'h44, 8'he4,
                                           8'h50, 8'h00, 8'h44, 8'h00};

  typedef struct packed {
    ecdma_pkg::cmd_t cmd;
    logic [6:0]      addr;
    logic [7:0]      data;
    logic [7:0]      mask;
    logic [4:0]      gap;
    logic            drain;
  } bus_op_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        busy;
    logic        mv;
    logic        from_b;
    logic [23:0] a_addr;
    logic [7:0]  b_addr;
    logic        last;
  } dma_reply_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  command     = ecdma_pkg::CMD_READ;
  logic [6:0]  reg_address = 7'd0;
  logic [7:0]  write_data  = 8'd0;
  logic [7:0]  start_mask  = 8'd0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  read_data;
  logic        was_busy;
  logic        move_valid;
  logic        move_from_b;
  logic [23:0] move_a_address;
  logic [7:0]  move_b_address;
  logic        move_last;

  eight_channel_dma_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .reg_address    (reg_address),
    .write_data     (write_data),
    .start_mask     (start_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .was_busy       (was_busy),
    .move_valid     (move_valid),
    .move_from_b    (move_from_b),
    .move_a_address (move_a_address),
    .move_b_address (move_b_address),
    .move_last      (move_last)
  );

  // engine model state
  logic [2:0]  ch_mode  [ecdma_pkg::MAX_CHANNELS];
  logic [4:0]  ch_flags [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  ch_bbase [ecdma_pkg::MAX_CHANNELS];
  logic [15:0] ch_aoff  [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  ch_abank [ecdma_pkg::MAX_CHANNELS];
  logic [15:0] ch_count [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  ch_ibank [ecdma_pkg::MAX_CHANNELS];
  logic [15:0] ch_table [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  ch_lines [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  ch_spare [ecdma_pkg::MAX_CHANNELS];
  logic        ch_run   [ecdma_pkg::MAX_CHANNELS];
  logic [1:0]  ch_phase [ecdma_pkg::MAX_CHANNELS];
  logic [7:0]  gap_timer;
  logic        engine_on;

  bus_op_t    cpu_bus_ops [$];
  dma_reply_t replies_due [$];
  bus_op_t    cur_op = '0;
  dma_reply_t want_reply;
  logic       drain_next = 1'b0;
  int         ops_planned = 0;
  int         send_wait = 0;
  int         recv_wait = 0;
  int         replies_checked = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         tally_reads = 0, tally_writes = 0, tally_starts = 0, tally_ticks = 0;
  int         tally_moves = 0, tally_done = 0;
  logic       offering;

  function automatic void engine_reset();
    for (int i = 0; i < ecdma_pkg::MAX_CHANNELS; i++) begin
      ch_mode[i]  = 3'd7;
      ch_flags[i] = 5'h1f;
      ch_bbase[i] = 8'hff;
      ch_aoff[i]  = 16'hffff;
      ch_abank[i] = 8'hff;
      ch_count[i] = 16'hffff;
      ch_ibank[i] = 8'hff;
      ch_table[i] = 16'hffff;
      ch_lines[i] = 8'hff;
      ch_spare[i] = 8'hff;
      ch_run[i]   = 1'b0;
      ch_phase[i] = 2'd0;
    end
    gap_timer = 8'd0;
    engine_on = 1'b0;
  endfunction

  function automatic logic [7:0] reg_peek(input logic [2:0] ch, input logic [3:0] r);
    case (r)
      ecdma_pkg::REG_CONTROL:    return {ch_flags[ch], ch_mode[ch]};
      ecdma_pkg::REG_B_BASE:     return ch_bbase[ch];
      ecdma_pkg::REG_A_OFF_LO:   return ch_aoff[ch][7:0];
      ecdma_pkg::REG_A_OFF_HI:   return ch_aoff[ch][15:8];
      ecdma_pkg::REG_A_BANK:     return ch_abank[ch];
      ecdma_pkg::REG_COUNT_LO:   return ch_count[ch][7:0];
      ecdma_pkg::REG_COUNT_HI:   return ch_count[ch][15:8];
      ecdma_pkg::REG_IND_BANK:   return ch_ibank[ch];
      ecdma_pkg::REG_TABLE_LO:   return ch_table[ch][7:0];
      ecdma_pkg::REG_TABLE_HI:   return ch_table[ch][15:8];
      ecdma_pkg::REG_LINE_COUNT: return ch_lines[ch];
      ecdma_pkg::REG_SPARE, ecdma_pkg::REG_SPARE_ALT: return ch_spare[ch];
      default:                   return 8'h00;
    endcase
  endfunction

  function automatic void reg_poke(input logic [2:0] ch, input logic [3:0] r,
                                   input logic [7:0] v);
    case (r)
      ecdma_pkg::REG_CONTROL: begin
        ch_mode[ch]  = v[2:0];
        ch_flags[ch] = v[7:3];
      end
      ecdma_pkg::REG_B_BASE:     ch_bbase[ch] = v;
      ecdma_pkg::REG_A_OFF_LO:   ch_aoff[ch][7:0] = v;
      ecdma_pkg::REG_A_OFF_HI:   ch_aoff[ch][15:8] = v;
      ecdma_pkg::REG_A_BANK:     ch_abank[ch] = v;
      ecdma_pkg::REG_COUNT_LO:   ch_count[ch][7:0] = v;
      ecdma_pkg::REG_COUNT_HI:   ch_count[ch][15:8] = v;
      ecdma_pkg::REG_IND_BANK:   ch_ibank[ch] = v;
      ecdma_pkg::REG_TABLE_LO:   ch_table[ch][7:0] = v;
      ecdma_pkg::REG_TABLE_HI:   ch_table[ch][15:8] = v;
      ecdma_pkg::REG_LINE_COUNT: ch_lines[ch] = v;
      ecdma_pkg::REG_SPARE, ecdma_pkg::REG_SPARE_ALT: ch_spare[ch] = v;
      default: ;
    endcase
  endfunction

  // one bus word through the engine model, returns the reply it should produce
  function automatic dma_reply_t advance_engine(input bus_op_t op);
    dma_reply_t rep;
    logic [2:0] ch;
    logic [3:0] r;
    logic [2:0] m;
    logic [1:0] s;
    logic [4:0] fl;
    logic       any;
    logic       found;
    rep = '0;
    ch  = op.addr[6:4];
    r   = op.addr[3:0];
    case (op.cmd)
      ecdma_pkg::CMD_READ: begin
        tally_reads++;
        if (ch < ecdma_pkg::CHANNEL_COUNT) rep.rd = reg_peek(ch, r);
      end
      ecdma_pkg::CMD_WRITE: begin
        tally_writes++;
        if (ch < ecdma_pkg::CHANNEL_COUNT) reg_poke(ch, r, op.data);
      end
      ecdma_pkg::CMD_START: begin
        tally_starts++;
        any = 1'b0;
        for (int i = 0; i < ecdma_pkg::MAX_CHANNELS; i++) begin
          ch_run[i] = (i < ecdma_pkg::CHANNEL_COUNT) && op.mask[i];
          any = any | ch_run[i];
        end
        engine_on = any;
        if (any) gap_timer = gap_timer + ecdma_pkg::TIMER_START;
      end
      default: begin
        tally_ticks++;
        if (engine_on) begin
          rep.busy = 1'b1;
          if (gap_timer != 8'd0) begin
            gap_timer = gap_timer - ecdma_pkg::TIMER_TICK;
          end else begin
            found = 1'b0;
            // lowest active channel wins the tick
            for (int i = 0; i < ecdma_pkg::CHANNEL_COUNT; i++) begin
              if (!found && ch_run[i]) begin
                found = 1'b1;
                m  = ch_mode[i];
                s  = ch_phase[i];
                fl = ch_flags[i];
                rep.mv     = 1'b1;
                rep.from_b = fl[ecdma_pkg::FLAG_FROM_B];
                rep.a_addr = {ch_abank[i], ch_aoff[i]};
                rep.b_addr = ch_bbase[i] + 8'(B_PATTERN[m][{s, 1'b0} +: 2]);
                ch_phase[i] = s + 2'd1;
                if (!fl[ecdma_pkg::FLAG_FIXED])
                  ch_aoff[i] = ch_aoff[i] +
                               (fl[ecdma_pkg::FLAG_DECREMENT] ? 16'hffff : 16'h0001);
                ch_count[i] = ch_count[i] - 16'd1;
                if (ch_count[i] == 16'd0) begin
                  ch_phase[i] = 2'd0;
                  ch_run[i]   = 1'b0;
                  gap_timer   = gap_timer + ecdma_pkg::TIMER_FINISH;
                  rep.last    = 1'b1;
                  tally_done++;
                end
                gap_timer = gap_timer + ecdma_pkg::TIMER_MOVE;
                tally_moves++;
              end
            end
            if (!found) engine_on = 1'b0;
          end
        end
      end
    endcase
    return rep;
  endfunction

  function automatic void match_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // stimulus planning
  task automatic add_op(input ecdma_pkg::cmd_t c, input logic [6:0] a, input logic [7:0] d,
                        input logic [7:0] m);
    bus_op_t op;
    logic    burst;
    // a stretch of back-to-back words every 200, never paused for draining
    burst   = (ops_planned % 200 >= 90) && (ops_planned % 200 < 170);
    op.cmd  = c;
    op.addr = a;
    op.data = d;
    op.mask = m;
    if (burst) op.gap = 5'd0;
    else op.gap = 5'($urandom_range(0, 17));
    op.drain   = drain_next && !burst;
    drain_next = 1'b0;
    cpu_bus_ops.push_back(op);
    ops_planned++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_read(input logic [2:0] ch, input logic [3:0] r);
    add_op(ecdma_pkg::CMD_READ, {ch, r}, 8'($urandom), 8'($urandom));
  endtask

  task automatic queue_write(input logic [2:0] ch, input logic [3:0] r, input logic [7:0] v);
    add_op(ecdma_pkg::CMD_WRITE, {ch, r}, v, 8'($urandom));
  endtask

  task automatic queue_start(input logic [7:0] m);
    add_op(ecdma_pkg::CMD_START, 7'($urandom), 8'($urandom), m);
  endtask

  task automatic queue_tick();
    add_op(ecdma_pkg::CMD_TICK, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // ticks with the odd register read of the running channel mixed in
  task automatic queue_ticks(input int n, input logic [2:0] ch);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) queue_read(ch, 4'($urandom));
      else queue_tick();
    end
  endtask

  task automatic plan_transfer();
    logic [2:0]  ch;
    logic [15:0] bytes;
    logic [7:0]  m;
    int          spins;
    ch = 3'($urandom);
    drain_next = ($urandom_range(0, 4) == 0);
    queue_write(ch, ecdma_pkg::REG_CONTROL, 8'($urandom));
    queue_write(ch, ecdma_pkg::REG_B_BASE, pick_byte());
    queue_write(ch, ecdma_pkg::REG_A_OFF_LO, pick_byte());
    if ($urandom_range(0, 1) == 1) queue_write(ch, ecdma_pkg::REG_A_OFF_HI, pick_byte());
    if ($urandom_range(0, 1) == 1) queue_write(ch, ecdma_pkg::REG_A_BANK, pick_byte());
    // zero count means a full 64k transfer
    bytes = ($urandom_range(0, 11) == 0) ? 16'h0000 : 16'($urandom_range(1, 5));
    queue_write(ch, ecdma_pkg::REG_COUNT_LO, bytes[7:0]);
    queue_write(ch, ecdma_pkg::REG_COUNT_HI, bytes[15:8]);
    // mostly keep lower channels out so this one gets the moves
    if ($urandom_range(0, 3) == 0) m = 8'($urandom);
    else m = (8'd1 << ch) | (8'($urandom) & ~((8'd2 << ch) - 8'd1));
    queue_start(m);
    spins = $urandom_range(8, 12 + 5 * ((bytes == 16'd0) ? 4 : int'(bytes)));
    queue_ticks(spins, ch);
  endtask

  task automatic plan_reg_scan();
    logic [6:0] a;
    repeat ($urandom_range(4, 10)) begin
      a = 7'($urandom);
      queue_write(a[6:4], a[3:0], pick_byte());
      queue_read(a[6:4], a[3:0]);
    end
  endtask

  task automatic plan_noise();
    repeat ($urandom_range(8, 20))
      add_op(ecdma_pkg::cmd_t'(2'($urandom)), 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a run of back-to-back starts that can wrap the wait timer, then let it run down
  task automatic plan_timer_wrap();
    repeat ($urandom_range(14, 17)) queue_start(8'($urandom_range(1, 255)));
    queue_ticks(140, 3'($urandom));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: offers the pending words in order, one nonblocking update per edge
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
      engine_reset();
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        replies_due.push_back(advance_engine(cur_op));
        offering = 1'b0;
        if (cpu_bus_ops.size() > 0) send_wait = cpu_bus_ops[0].gap;
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (cpu_bus_ops.size() > 0 &&
                     (!cpu_bus_ops[0].drain || replies_due.size() == 0)) begin
          cur_op   = cpu_bus_ops.pop_front();
          offering = 1'b1;
        end
      end
      in_valid    <= offering;
      command     <= cur_op.cmd;
      reg_address <= cur_op.addr;
      write_data  <= cur_op.data;
      start_mask  <= cur_op.mask;
    end
  end

  // monitor: checks each reply word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("reply word arrived with nothing outstanding");
          mismatches++;
        end else begin
          want_reply = replies_due.pop_front();
          match_field("read_data", 24'(want_reply.rd), 24'(read_data));
          match_field("was_busy", 24'(want_reply.busy), 24'(was_busy));
          match_field("move_valid", 24'(want_reply.mv), 24'(move_valid));
          match_field("move_from_b", 24'(want_reply.from_b), 24'(move_from_b));
          match_field("move_a_address", want_reply.a_addr, move_a_address);
          match_field("move_b_address", 24'(want_reply.b_addr), 24'(move_b_address));
          match_field("move_last", 24'(want_reply.last), 24'(move_last));
        end
        replies_checked++;
        if (replies_checked % 200 >= 20 && replies_checked % 200 < 80) recv_wait = 0;
        else recv_wait = $urandom_range(0, 17);
        // one long back-pressure stretch while the sender keeps offering
        if (replies_checked == LONG_HOLD_AT) recv_wait = LONG_HOLD_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, replies_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int  pick;
    bit  wrap_done;
    int  random_goal;
    wrap_done = 1'b0;

    // reset values, register holes, idle tick, empty start
    queue_read(3'd0, ecdma_pkg::REG_CONTROL);
    queue_read(3'd7, ecdma_pkg::REG_SPARE_ALT);
    queue_write(3'd2, REG_HOLE_LO, 8'h00);
    queue_read(3'd2, REG_HOLE_LO);
    queue_read(3'd5, REG_HOLE_MID);
    queue_read(3'd6, REG_HOLE_HI);
    queue_tick();
    queue_start(8'h00);
    // single byte from b, mode 4, offset wraps from ffff
    queue_write(3'd0, ecdma_pkg::REG_CONTROL, 8'h84);
    queue_write(3'd0, ecdma_pkg::REG_COUNT_LO, 8'h01);
    queue_write(3'd0, ecdma_pkg::REG_COUNT_HI, 8'h00);
    queue_start(8'h01);
    repeat (10) queue_tick();
    queue_read(3'd0, ecdma_pkg::REG_A_OFF_LO);
    queue_read(3'd0, ecdma_pkg::REG_COUNT_LO);

    random_goal = ops_planned + RANDOM_WORDS;
    drain_next  = 1'b1;
    while (ops_planned < random_goal) begin
      pick = $urandom_range(0, 99);
      if (!wrap_done && ops_planned >= 200) begin
        plan_timer_wrap();
        wrap_done = 1'b1;
      end else if (pick < 55) plan_transfer();
      else if (pick < 75) plan_reg_scan();
      else if (pick < 97) plan_noise();
      else plan_timer_wrap();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cpu_bus_ops.size() != 0 || in_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d reads, %0d writes, %0d starts, %0d ticks",
             replies_checked, tally_reads, tally_writes, tally_starts, tally_ticks);
    $display("%0d byte moves and %0d channel completions predicted, %0d mismatches",
             tally_moves, tally_done, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: eight_channel_dma_controller.f
+incdir+sv
sv/ecdma_pkg.sv
sv/ecdma_move_unit.sv
sv/eight_channel_dma_controller.sv
test/tb_eight_channel_dma_controller.sv
